### rtl/sxh_pkg.sv
// shared types, constants and symbol helpers for the shift-xor hash checker
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package sxh_pkg;

	localparam int MaxLength  = 12;
	localparam int IndexBits  = 63;
	localparam int DigitBits  = 6;
	localparam int NumSymbols = 36;
	localparam int HalfBase   = NumSymbols / 2;
	localparam int NumLetters = 26;

	// configuration register indexes
	localparam logic [2:0] RegTargetHash   = 3'd0;
	localparam logic [2:0] RegEndShift     = 3'd1;
	localparam logic [2:0] RegWordlikeEn   = 3'd2;
	localparam logic [2:0] RegMaxConsonant = 3'd3;
	localparam logic [2:0] RegStringLength = 3'd4;

	typedef logic [DigitBits-1:0] digit_t;
	typedef digit_t [MaxLength-1:0] digits_t;

	typedef enum logic [1:0] {
		SymConsonant = 2'd0,
		SymVowel     = 2'd1,
		SymDigit     = 2'd2
	} sym_class_t;

	// running state handed from one symbol cell to the next
	typedef struct packed {
		logic [31:0] hash;
		logic [4:0]  shift;
		logic        vowel_seen;
		logic [3:0]  digit_cnt;
		logic [3:0]  run;
		logic [1:0]  same;
		digit_t      prev;
		logic        prev_ok;
		logic        word_ok;
	} sym_state_t;

	function automatic sym_class_t sym_class(input digit_t d);
		sym_class_t c;
		if (d >= digit_t'(NumLetters)) begin
			c = SymDigit;
		end else if (d == 6'd0 || d == 6'd4 || d == 6'd8 || d == 6'd14 ||
		             d == 6'd20 || d == 6'd24) begin
			c = SymVowel;
		end else begin
			c = SymConsonant;
		end
		return c;
	endfunction

	// letters step 1..26, digits step 6..15
	function automatic logic [4:0] sym_step(input digit_t d);
		logic [4:0] s;
		if (d < digit_t'(NumLetters)) begin
			s = 5'(d + 6'd1);
		end else begin
			s = 5'(d - 6'd20);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/shift_xor_hash_candidate_check.sv
// top level of the shift-xor hash candidate checker: config registers, cell chains
// and output register; depends on sxh_pkg, sxh_conv_cell and sxh_sym_cell
// pipeline of 63 conversion cells (one per index bit), 12 symbol cells and an output register
// throughput one candidate per cycle; the whole chain moves together and stalls
// only while a result waits on the output and m_tready is low
// arst_n clears valid bits and loads the register reset values; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module shift_xor_hash_candidate_check (
	input  wire         clk,
	input  wire         arst_n,
	// candidate request: [62:0] candidate_index, [63] zero
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,
	// result: [0] matched, [32:1] hash_value, [37:33] final_shift,
	// [38] is_wordlike, [39] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,
	// configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import sxh_pkg::*;

	// configuration registers
	logic [31:0] target_hash_q;
	logic [5:0]  end_shift_q;
	logic        wordlike_en_q;
	logic [3:0]  max_run_q;
	logic [3:0]  str_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_hash_q <= 32'd0;
			end_shift_q   <= 6'h3f;
			wordlike_en_q <= 1'b0;
			max_run_q     <= 4'd3;
			str_len_q     <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegTargetHash:   target_hash_q <= cfg_data;
				RegEndShift:     end_shift_q   <= cfg_data[5:0];
				RegWordlikeEn:   wordlike_en_q <= cfg_data[0];
				RegMaxConsonant: max_run_q     <= cfg_data[3:0];
				RegStringLength: str_len_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// length zero acts as one, anything above the maximum saturates
	logic [3:0] len_eff;
	always_comb begin
		if (str_len_q == 4'd0) begin
			len_eff = 4'd1;
		end else if (str_len_q > 4'(MaxLength)) begin
			len_eff = 4'(MaxLength);
		end else begin
			len_eff = str_len_q;
		end
	end

	// one shared advance for the whole chain
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// conversion chain: feeds the index in msb first, digits double each cell;
	// carries out of the top digit fall away, giving the index modulo 36^12
	logic        conv_valid  [IndexBits+1];
	logic [62:0] conv_idx    [IndexBits+1];
	digits_t     conv_digits [IndexBits+1];

	assign conv_valid[0]  = s_tvalid;
	assign conv_idx[0]    = s_tdata[IndexBits-1:0];
	assign conv_digits[0] = '0;

	for (genvar k = 0; k < IndexBits; k++) begin : g_conv
		sxh_conv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.valid_in   (conv_valid[k]),
			.idx_in     (conv_idx[k]),
			.digits_in  (conv_digits[k]),
			.valid_out  (conv_valid[k+1]),
			.idx_out    (conv_idx[k+1]),
			.digits_out (conv_digits[k+1])
		);
	end

	// symbol chain: cell p handles the p-th least significant digit, idle past length
	logic        sym_valid  [MaxLength+1];
	digits_t     sym_digits [MaxLength+1];
	sym_state_t  sym_state  [MaxLength+1];

	assign sym_valid[0]  = conv_valid[IndexBits];
	assign sym_digits[0] = conv_digits[IndexBits];

	// empty state entering the first symbol cell
	assign sym_state[0] = '{hash: 32'd0, shift: 5'd0, vowel_seen: 1'b0, digit_cnt: 4'd0,
	                        run: 4'd0, same: 2'd1, prev: '0, prev_ok: 1'b0,
	                        word_ok: 1'b1};

	for (genvar p = 0; p < MaxLength; p++) begin : g_sym
		sxh_sym_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.valid_in   (sym_valid[p]),
			.active     (len_eff > 4'(p)),
			.max_run    (max_run_q),
			.digit      (sym_digits[p][p]),
			.digits_in  (sym_digits[p]),
			.state_in   (sym_state[p]),
			.valid_out  (sym_valid[p+1]),
			.digits_out (sym_digits[p+1]),
			.state_out  (sym_state[p+1])
		);
	end

	// final verdict and output register
	sym_state_t fin;
	logic       word_ok;
	logic       shift_ok;
	logic       match;

	always_comb begin
		fin      = sym_state[MaxLength];
		word_ok  = fin.word_ok && fin.vowel_seen &&
		           !({fin.digit_cnt, 1'b0} > {1'b0, len_eff});
		// a negative filter value takes any shift
		shift_ok = end_shift_q[5] || (end_shift_q[4:0] == fin.shift);
		match    = (fin.hash == target_hash_q) && shift_ok && (!wordlike_en_q || word_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= sym_valid[MaxLength];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {1'b0, word_ok, fin.shift, fin.hash, match};
		end
	end

	// checks on the chain control
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> conv_valid[1])
		else $error("accepted request did not enter the first conversion cell");

	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sym_valid[MaxLength]) && $stable(conv_valid[IndexBits]))
		else $error("chain moved during an output stall");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while a result is stalled");

endmodule

`default_nettype wire

### rtl/sxh_conv_cell.sv
// one binary-to-base-36 conversion cell: folds one index bit into the digit row
// depends on sxh_pkg
`timescale 1ns / 1ps
`default_nettype none

module sxh_conv_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      valid_in,
	input  wire [62:0]               idx_in,
	input  sxh_pkg::digits_t         digits_in,
	output logic                     valid_out,
	output logic [62:0]              idx_out,
	output sxh_pkg::digits_t         digits_out
);
	import sxh_pkg::*;

	digits_t                doubled;
	logic [MaxLength:0]     carry;
	logic [DigitBits:0]     wide [MaxLength];

	// doubling a digit overflows exactly when it is 18 or more, whatever the carry in
	always_comb begin
		carry[0] = idx_in[IndexBits-1];
		for (int i = 0; i < MaxLength; i++) begin
			carry[i+1] = (digits_in[i] >= digit_t'(HalfBase));
			wide[i]    = {digits_in[i], carry[i]};
			if (carry[i+1]) begin
				wide[i] = wide[i] - (DigitBits+1)'(NumSymbols);
			end
			doubled[i] = wide[i][DigitBits-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_out    <= {idx_in[IndexBits-2:0], 1'b0};
			digits_out <= doubled;
		end
	end

endmodule

`default_nettype wire

### rtl/sxh_sym_cell.sv
// one symbol cell: when active, advances shift, toggles the hash bit and runs the word filter
// depends on sxh_pkg
`timescale 1ns / 1ps
`default_nettype none

module sxh_sym_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      valid_in,
	input  wire                      active,
	input  wire [3:0]                max_run,
	input  sxh_pkg::digit_t          digit,
	input  sxh_pkg::digits_t         digits_in,
	input  sxh_pkg::sym_state_t      state_in,
	output logic                     valid_out,
	output sxh_pkg::digits_t         digits_out,
	output sxh_pkg::sym_state_t      state_out
);
	import sxh_pkg::*;

	sym_state_t nxt;
	sym_class_t cls;
	logic [4:0] new_shift;
	logic       repeat_sym;

	always_comb begin
		nxt        = state_in;
		cls        = sym_class(digit);
		new_shift  = state_in.shift + sym_step(digit);
		repeat_sym = state_in.prev_ok && (state_in.prev == digit);
		if (active) begin
			nxt.shift = new_shift;
			nxt.hash  = state_in.hash ^ (32'd1 << new_shift);
			case (cls)
				SymDigit: begin
					nxt.digit_cnt = state_in.digit_cnt + 4'd1;
					nxt.run       = 4'd0;
				end
				SymVowel: begin
					nxt.vowel_seen = 1'b1;
					nxt.run        = 4'd0;
				end
				default: begin
					nxt.run = state_in.run + 4'd1;
					if (nxt.run > max_run) begin
						nxt.word_ok = 1'b0;
					end
				end
			endcase
			if (repeat_sym) begin
				if (state_in.same != 2'd3) begin
					nxt.same = state_in.same + 2'd1;
				end
				if (state_in.same >= 2'd2) begin
					nxt.word_ok = 1'b0;
				end
			end else begin
				nxt.same = 2'd1;
			end
			nxt.prev    = digit;
			nxt.prev_ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			digits_out <= digits_in;
			state_out  <= nxt;
		end
	end

endmodule

`default_nettype wire

### test/shift_xor_hash_candidate_check_tb.sv
// self-checking testbench for the shift-xor hash candidate checker
// depends on sxh_pkg and shift_xor_hash_candidate_check; random stalls on both streams
// carries its own predictor of hash, end shift and word-like verdict
`timescale 1ns / 1ps

module shift_xor_hash_candidate_check_tb;

	import sxh_pkg::*;

	localparam int NumPhases     = 12;
	localparam int PhaseItems    = 125;
	localparam int LatencyCycles = 76;
	localparam int CycleLimit    = 200000;
	localparam int IdlePercent   = 15;

	// index outside the register map, writes to it must change nothing
	localparam logic [2:0] RegUnused = 3'd7;

	// register copy kept by the testbench
	typedef struct packed {
		logic [31:0] target_hash;
		logic [5:0]  end_shift_filter;
		logic        wordlike_enable;
		logic [3:0]  max_consonant_run;
		logic [3:0]  string_length;
	} cfg_t;

	localparam cfg_t CfgAtReset = '{
		target_hash: 32'd0,
		end_shift_filter: 6'h3F,
		wordlike_enable: 1'b0,
		max_consonant_run: 4'd3,
		string_length: 4'd8
	};

	// one result: matched, hash, shift after the last symbol, word-like verdict
	typedef struct packed {
		logic        is_wordlike;
		logic [4:0]  final_shift;
		logic [31:0] hash_value;
		logic        matched;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	cfg_t        cfg_now = CfgAtReset;
	logic [62:0] index_q[$];
	verdict_t    verdict_q[$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	shift_xor_hash_candidate_check u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// splits the index into base-36 symbols and walks them once,
	// keeping the shift, the hash and the word-like bookkeeping
	function automatic verdict_t hash_candidate(input cfg_t c, input logic [62:0] index);
		verdict_t    v;
		logic [62:0] rest;
		logic [4:0]  shift;
		logic [31:0] hash;
		int unsigned len, d, prev, run, same, n_digits, n_vowels;
		sym_class_t  kind;
		logic        word_ok;
		// zero length counts as one symbol, anything past the maximum saturates
		if (c.string_length == 0) begin
			len = 1;
		end else if (c.string_length > MaxLength) begin
			len = MaxLength;
		end else begin
			len = 32'(c.string_length);
		end
		rest = index;
		shift = '0;
		hash = '0;
		prev = NumSymbols;
		run = 0;
		same = 1;
		n_digits = 0;
		n_vowels = 0;
		word_ok = 1'b1;
		for (int p = 0; p < len; p++) begin
			d = 32'(rest % NumSymbols);
			rest = rest / NumSymbols;
			if (d >= NumLetters) begin
				kind = SymDigit;
			end else begin
				// A E I O U Y
				case (d)
					0, 4, 8, 14, 20, 24: kind = SymVowel;
					default: kind = SymConsonant;
				endcase
			end
			// letters advance 1..26, digits 6..15
			shift = shift + ((kind == SymDigit) ? 5'(d - 20) : 5'(d + 1));
			hash ^= 32'd1 << shift;
			case (kind)
				SymDigit: begin
					n_digits++;
					run = 0;
				end
				SymVowel: begin
					n_vowels++;
					run = 0;
				end
				default: begin
					run++;
					if (run > c.max_consonant_run) word_ok = 1'b0;
				end
			endcase
			if (d == prev) begin
				same++;
				if (same >= 3) word_ok = 1'b0;
			end else begin
				same = 1;
			end
			prev = d;
		end
		if (n_vowels == 0) word_ok = 1'b0;
		if (2 * n_digits > len) word_ok = 1'b0;
		v.hash_value = hash;
		v.final_shift = shift;
		v.is_wordlike = word_ok;
		// a negative end shift filter accepts any shift
		v.matched = (hash == c.target_hash) &&
		            (c.end_shift_filter[5] || c.end_shift_filter[4:0] == shift) &&
		            (!c.wordlike_enable || word_ok);
		return v;
	endfunction

	// index of a spelled candidate, first character least significant
	function automatic logic [62:0] word_index(input string w);
		logic [62:0] v;
		logic [62:0] scale;
		int unsigned d;
		v = '0;
		scale = 63'd1;
		for (int i = 0; i < w.len(); i++) begin
			if (w[i] >= "A" && w[i] <= "Z") begin
				d = 32'(w[i] - "A");
			end else begin
				d = w[i] - "0" + NumLetters;
			end
			v += scale * d;
			scale *= NumSymbols;
		end
		return v;
	endfunction

	// twelve symbols biased towards vowels, repeats and consonant runs;
	// symbols past the configured length land in the ignored upper digits
	function automatic logic [62:0] random_word();
		int unsigned vowel_sym[6] = '{0, 4, 8, 14, 20, 24};
		logic [62:0] v;
		logic [62:0] scale;
		int unsigned d, prev, r;
		v = '0;
		scale = 63'd1;
		prev = $urandom_range(NumSymbols - 1);
		for (int i = 0; i < MaxLength; i++) begin
			r = $urandom_range(99);
			if (r < 15) begin
				d = prev;
			end else if (r < 45) begin
				d = vowel_sym[$urandom_range(5)];
			end else if (r < 80) begin
				d = $urandom_range(NumLetters - 1);
			end else begin
				d = NumLetters + $urandom_range(9);
			end
			v += scale * d;
			scale *= NumSymbols;
			prev = d;
		end
		return v;
	endfunction

	task automatic report_mismatch(input string field_name, input logic [63:0] want,
	                               input logic [63:0] got);
		$display("mismatch %s: expected %0h, got %0h at %0t", field_name, want, got, $time);
		error_count++;
	endtask

	// candidate sender: a request is predicted at the edge it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				verdict_q.push_back(hash_candidate(cfg_now, s_tdata[62:0]));
			end
			if (!s_tvalid || s_tready) begin
				if (index_q.size() != 0 && (no_idle || $urandom_range(99) >= IdlePercent)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, index_q.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver: compares each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", '0, 64'(m_tdata));
				end else begin
					verdict_t want;
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want.matched)
						report_mismatch("matched", 64'(want.matched), 64'(m_tdata[0]));
					if (m_tdata[32:1] !== want.hash_value)
						report_mismatch("hash_value", 64'(want.hash_value),
						                64'(m_tdata[32:1]));
					if (m_tdata[37:33] !== want.final_shift)
						report_mismatch("final_shift", 64'(want.final_shift),
						                64'(m_tdata[37:33]));
					if (m_tdata[38] !== want.is_wordlike)
						report_mismatch("is_wordlike", 64'(want.is_wordlike),
						                64'(m_tdata[38]));
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= IdlePercent);
		end
	end

	// register copy follows every accepted write, unknown indexes are dropped
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_now <= CfgAtReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegTargetHash:   cfg_now.target_hash <= cfg_data;
				RegEndShift:     cfg_now.end_shift_filter <= cfg_data[5:0];
				RegWordlikeEn:   cfg_now.wordlike_enable <= cfg_data[0];
				RegMaxConsonant: cfg_now.max_consonant_run <= cfg_data[3:0];
				RegStringLength: cfg_now.string_length <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// register write; bits above the register width carry junk
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value, input int bits);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ($urandom << bits) | value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// every queued candidate taken and every result back
	task automatic drain();
		while (index_q.size() != 0 || s_tvalid || verdict_q.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		string       words[17] = '{
			"AAAAAAAA", "99999999", "BANANAS1", "STRAWBXY", "STRKAMEN", "BCDFGHJK",
			"A1234567", "AB12C34E", "AB12C345", "HELLLO00", "ABCDEFGH", "IJKLMNOP",
			"QRSTUVWX", "YZ012345", "6789AAAA", "AAAAAAAAB", "WORDLIKEZZ"
		};
		int unsigned len_plan[NumPhases] = '{1, 12, 0, 15, 2, 5, 8, 11, 3, 13, 6, 12};
		cfg_t        c;
		logic [62:0] seed;
		verdict_t    seed_v;
		int unsigned r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed candidates at the reset settings: extremes, every symbol,
		// consonant run at and over the limit, triple repeat, no vowel,
		// digit share on and over half, digits beyond the length
		index_q.push_back('0);
		index_q.push_back('1);
		foreach (words[i]) index_q.push_back(word_index(words[i]));
		drain();

		for (int ph = 0; ph < NumPhases; ph++) begin
			c.string_length = 4'(len_plan[ph]);
			c.max_consonant_run = (ph == 1) ? 4'd0 : (ph == 3) ? 4'd15 :
			                      (ph == 5) ? 4'd12 : 4'($urandom_range(15));
			c.wordlike_enable = 1'(ph % 2);
			c.target_hash = '0;
			c.end_shift_filter = 6'h3F;
			// a seed candidate gives a reachable target so that matches occur
			seed = random_word();
			seed_v = hash_candidate(c, seed);
			c.target_hash = (ph == 2) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : seed_v.hash_value;
			case (ph % 4)
				0: c.end_shift_filter = 6'h3F;
				1: c.end_shift_filter = {1'b0, seed_v.final_shift};
				2: c.end_shift_filter = 6'h20;
				default: c.end_shift_filter = 6'($urandom_range(63));
			endcase
			if (ph == 6) c.end_shift_filter = 6'h1F;
			if (ph == 7) c.end_shift_filter = 6'h00;

			drain();
			if (ph == 0) write_reg(RegUnused, $urandom, 32);
			write_reg(RegStringLength, 32'(c.string_length), 4);
			write_reg(RegMaxConsonant, 32'(c.max_consonant_run), 4);
			write_reg(RegWordlikeEn, 32'(c.wordlike_enable), 1);
			write_reg(RegEndShift, 32'(c.end_shift_filter), 6);
			write_reg(RegTargetHash, c.target_hash, 32);

			// one phase runs with both streams flat out
			no_idle = (ph == 5);
			for (int i = 0; i < PhaseItems; i++) begin
				r = $urandom_range(99);
				if (r < 10) begin
					index_q.push_back(seed);
				end else if (r < 35) begin
					index_q.push_back(63'({$urandom, $urandom}));
				end else begin
					index_q.push_back(random_word());
				end
				// sender holds off mid-phase until the pipe is empty
				if (ph == 3 && i == PhaseItems / 2) drain();
			end
		end

		drain();
		repeat (LatencyCycles + 24) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
